### src/pbt_pkg.sv
`default_nettype none
package pbt_pkg;

    localparam int WORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_START_POS  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_END_POS    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TOTAL_TIME = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ACCEL_REQ  = 3'd3;

    // Profile segment codes
    localparam logic [1:0] PH_ACCEL  = 2'd0;
    localparam logic [1:0] PH_CRUISE = 2'd1;
    localparam logic [1:0] PH_DECEL  = 2'd2;

    // Status of one serial arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } pbt_unit_stat_t;

endpackage
`default_nettype wire

### src/pbt_if.sv
`default_nettype none
interface pbt_sample_if #(parameter int WORD_WIDTH = 32);
    logic                  valid;
    logic                  ready;
    logic [WORD_WIDTH-1:0] sample_time;
    modport source (output valid, output sample_time, input ready);
    modport sink   (input valid, input sample_time, output ready);
endinterface

interface pbt_result_if #(parameter int WORD_WIDTH = 32);
    logic                         valid;
    logic                         ready;
    logic signed [WORD_WIDTH-1:0] position;
    logic [1:0]                   phase;
    logic                         saturated;
    modport source (output valid, output position, output phase, output saturated, input ready);
    modport sink   (input valid, input position, input phase, input saturated, output ready);
endinterface

interface pbt_cfg_if #(parameter int WORD_WIDTH = 32, parameter int INDEX_W = 3);
    logic                  valid;
    logic                  ready;
    logic [INDEX_W-1:0]    index;
    logic [WORD_WIDTH-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### src/pbt_mul.sv
`default_nettype none
module pbt_mul
    import pbt_pkg::*;
#(
    parameter int AW = 65,
    parameter int BW = 33
)(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [AW-1:0]     a,
    input  wire logic [BW-1:0]     b,
    output pbt_unit_stat_t         stat,
    output logic [AW+BW-1:0]       prod
);
    localparam int CNT_W = $clog2(BW + 1);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [AW+BW-1:0]    mcand_reg;
    logic [BW-1:0]       mplier_reg;
    logic [AW+BW-1:0]    prod_reg;
    logic                last;

    assign last = (cnt_reg == CNT_W'(BW - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                busy_reg <= !last;
                cnt_reg  <= cnt_reg + CNT_W'(1);
            end
        end
    end

    // One multiplier bit per cycle, LSB first
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg  <= (AW+BW)'(a);
            mplier_reg <= b;
            prod_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                prod_reg <= prod_reg + mcand_reg;
            end
            mcand_reg  <= mcand_reg << 1;
            mplier_reg <= mplier_reg >> 1;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign prod      = prod_reg;
endmodule
`default_nettype wire

### src/pbt_div.sv
`default_nettype none
module pbt_div
    import pbt_pkg::*;
#(
    parameter int NW = 66,
    parameter int DW = 64
)(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output pbt_unit_stat_t     stat,
    output logic [NW-1:0]      quo,
    output logic               rem_nz
);
    localparam int CNT_W = $clog2(NW + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NW-1:0]    num_reg;
    logic [DW-1:0]    den_reg;
    logic [DW-1:0]    rem_reg;
    logic [NW-1:0]    quo_reg;
    logic [DW:0]      trial;
    logic [DW:0]      diff;
    logic             fits;
    logic             last;

    assign last  = (cnt_reg == CNT_W'(NW - 1));
    assign trial = {rem_reg, num_reg[NW-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                busy_reg <= !last;
                cnt_reg  <= cnt_reg + CNT_W'(1);
            end
        end
    end

    // Restoring division, one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= num_reg << 1;
            rem_reg <= fits ? diff[DW-1:0] : trial[DW-1:0];
            quo_reg <= {quo_reg[NW-2:0], fits};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quo       = quo_reg;
    assign rem_nz    = |rem_reg;
endmodule
`default_nettype wire

### src/pbt_sqrt.sv
`default_nettype none
module pbt_sqrt
    import pbt_pkg::*;
#(
    parameter int RW = 64
)(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [RW-1:0]    rad,
    output pbt_unit_stat_t        stat,
    output logic [RW/2-1:0]       root
);
    localparam int HW    = RW / 2;
    localparam int CNT_W = $clog2(HW + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [RW-1:0]    rad_reg;
    logic [HW+1:0]    rem_reg;
    logic [HW-1:0]    root_reg;
    logic [HW+1:0]    shifted;
    logic [HW+1:0]    trial;
    logic             fits;
    logic             last;

    assign last    = (cnt_reg == CNT_W'(HW - 1));
    assign shifted = {rem_reg[HW-1:0], rad_reg[RW-1:RW-2]};
    assign trial   = {root_reg, 2'b01};
    assign fits    = (shifted >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                busy_reg <= !last;
                cnt_reg  <= cnt_reg + CNT_W'(1);
            end
        end
    end

    // Two radicand bits, one root bit per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= rad;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= fits ? (shifted - trial) : shifted;
            root_reg <= {root_reg[HW-2:0], fits};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign root      = root_reg;
endmodule
`default_nettype wire

### src/parabolic_blend_trajectory_top.sv
`default_nettype none
// Channel     | Dir | Words carry
// ------------+-----+-------------------------------------------
// sample_in   | in  | sample_time (unsigned Q16.16)
// result_out  | out | position (signed, saturated), phase, saturated
// cfg         | in  | index, data: register write, always ready
//
// Sequence: a word with cached blend parameters takes 2 or 3 passes of the
//   bit-serial multiplier; the result is then loaded into the output
//   register and the sequencer returns to idle to take the next word.
// The first word after reset or a write to a known register also runs
//   the blend solve: one multiply, two serial divisions and a
//   WORD_WIDTH-step square root; zero acceleration skips the second
//   division and the root.
// Reset clears control state and loads the register defaults.
// A finished word waits in the output register; sample_in is ready again
//   as soon as the result is parked there.
module parabolic_blend_trajectory_top
    import pbt_pkg::*;
#(
    parameter int WORD_WIDTH = WORD_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)(
    input  wire logic   clk,
    input  wire logic   rst_n,
    pbt_sample_if.sink  sample_in,
    pbt_result_if.source result_out,
    pbt_cfg_if.sink     cfg
);
    localparam int W  = WORD_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int NW = W + 2*F + 2;       // division numerator width
    localparam int DW = 2*W;               // division divisor width
    localparam int MA = 2*W + 1;           // multiplicand width
    localparam int MB = W + 1;             // multiplier width
    localparam int PW = MA + MB;           // product width
    localparam int MW = PW - 2*F - 1;      // scaled product width
    localparam int CW = (NW > DW) ? NW : DW;

    localparam logic [W-2:0]  AMAX  = {(W-1){1'b1}};
    localparam logic [MW-1:0] M_LIM = MW'({{W{1'b1}}, 1'b0});

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_T2    = 9'b000000010,
        S_AMIN  = 9'b000000100,
        S_QD    = 9'b000001000,
        S_SQRT  = 9'b000010000,
        S_K1    = 9'b000100000,
        S_K2    = 9'b001000000,
        S_SCALE = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;

    state_t          state_reg, state_next;
    logic            kick_reg, kick_next;

    // Configuration registers
    logic [W-1:0]    start_reg, end_reg, ttime_reg, areq_reg;

    // Cached blend
    logic [W-1:0]    blend_time_reg;
    logic [W-1:0]    blend_accel_reg;
    logic            blend_valid_reg;

    // Work registers
    logic [W-1:0]    t_reg;
    logic [DW-1:0]   t2_reg;
    logic [W-2:0]    acalc_reg;
    logic [DW-1:0]   r_reg;
    logic [MA-1:0]   k_reg;

    logic            out_valid_reg;
    logic [W-1:0]    out_pos_reg;
    logic [1:0]      out_phase_reg;
    logic            out_sat_reg;

    // Unit hookup
    pbt_unit_stat_t  mul_stat, div_stat, sqrt_stat;
    logic            mul_start, div_start, sqrt_start;
    logic [MA-1:0]   mul_a;
    logic [MB-1:0]   mul_b;
    logic [PW-1:0]   mul_prod;
    logic [NW-1:0]   div_num;
    logic [DW-1:0]   div_den;
    logic [NW-1:0]   div_quo;
    logic            div_rem_nz;
    logic [W-1:0]    sqrt_root;

    // Derived values
    logic            down;
    logic [W:0]      diff;
    logic [W-1:0]    span;
    logic [W-1:0]    tt;
    logic [W-1:0]    half;
    logic [W-1:0]    areq_mag;
    logic [NW:0]     qc;
    logic [W-2:0]    amin;
    logic [W-2:0]    anew;
    logic [CW-1:0]   quarter_x, qd_x;
    logic [W-1:0]    tb_new;
    logic [1:0]      phase;
    logic [W-1:0]    u;
    logic [W-1:0]    abs_blend;
    logic            neg;
    logic [MW-1:0]   m;
    logic            m_big;
    logic [W+2:0]    p0_x, m_x, sum_x;
    logic            sat_hi, sat_lo;
    logic [W-1:0]    pos_fin;
    logic            sat_fin;
    logic            in_acc, cfg_acc, out_load;

    assign down     = $signed(start_reg) > $signed(end_reg);
    assign diff     = {end_reg[W-1], end_reg} - {start_reg[W-1], start_reg};
    assign span     = down ? W'(-diff) : diff[W-1:0];
    assign tt       = (ttime_reg == '0) ? W'(1) : ttime_reg;
    assign half     = tt >> 1;
    assign areq_mag = areq_reg[W-1] ? (-areq_reg) : areq_reg;

    // Minimum acceleration: ceil(4*D*2^2F / T^2), clamped
    assign qc   = {1'b0, div_quo} + (NW+1)'(div_rem_nz);
    assign amin = (qc > (NW+1)'(AMAX)) ? AMAX : qc[W-2:0];
    assign anew = (areq_mag > W'(AMAX)) ? AMAX
                : ((areq_mag[W-2:0] > amin) ? areq_mag[W-2:0] : amin);

    assign quarter_x = CW'(t2_reg >> 2);
    assign qd_x      = CW'(div_quo);
    assign tb_new    = (half > sqrt_root) ? (half - sqrt_root) : '0;

    // Segment of the current word
    always_comb
    begin
        if (t_reg <= blend_time_reg)
        begin
            phase = PH_ACCEL;
        end
        else if (t_reg <= tt - blend_time_reg)
        begin
            phase = PH_CRUISE;
        end
        else
        begin
            phase = PH_DECEL;
        end
    end

    assign u         = (t_reg > tt) ? '0 : (tt - t_reg);
    assign neg       = blend_accel_reg[W-1];
    assign abs_blend = neg ? (-blend_accel_reg) : blend_accel_reg;

    // Final scale, offset and clip
    assign m      = mul_prod[PW-1:2*F+1];
    assign m_big  = (m > M_LIM);
    assign p0_x   = {{3{start_reg[W-1]}}, start_reg};
    assign m_x    = {2'b00, m[W:0]};
    assign sum_x  = neg ? (p0_x - m_x) : (p0_x + m_x);
    assign sat_hi = !sum_x[W+2] && (sum_x[W+1:W-1] != 3'b000);
    assign sat_lo = sum_x[W+2] && (sum_x[W+1:W-1] != 3'b111);

    always_comb
    begin
        if (m_big)
        begin
            sat_fin = 1'b1;
            pos_fin = neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, AMAX};
        end
        else if (sat_hi)
        begin
            sat_fin = 1'b1;
            pos_fin = {1'b0, AMAX};
        end
        else if (sat_lo)
        begin
            sat_fin = 1'b1;
            pos_fin = {1'b1, {(W-1){1'b0}}};
        end
        else
        begin
            sat_fin = 1'b0;
            pos_fin = sum_x[W-1:0];
        end
    end

    // Multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_T2:
            begin
                mul_a = MA'(tt);
                mul_b = MB'(tt);
            end
            S_K1:
            begin
                case (phase)
                    PH_ACCEL:
                    begin
                        mul_a = MA'(t_reg);
                        mul_b = MB'(t_reg);
                    end
                    PH_CRUISE:
                    begin
                        mul_a = MA'(blend_time_reg);
                        mul_b = {t_reg, 1'b0} - MB'(blend_time_reg);
                    end
                    default:
                    begin
                        mul_a = MA'({blend_time_reg, 1'b0});
                        mul_b = MB'(tt - blend_time_reg);
                    end
                endcase
            end
            S_K2:
            begin
                mul_a = MA'(u);
                mul_b = MB'(u);
            end
            S_SCALE:
            begin
                mul_a = k_reg;
                mul_b = MB'(abs_blend);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign div_num = (state_reg == S_AMIN) ? (NW'(span) << (2*F + 2))
                                           : (NW'(span) << (2*F));
    assign div_den = (state_reg == S_AMIN) ? t2_reg : DW'(acalc_reg);

    assign mul_start  = kick_reg && ((state_reg == S_T2) || (state_reg == S_K1)
                        || (state_reg == S_K2) || (state_reg == S_SCALE));
    assign div_start  = kick_reg && ((state_reg == S_AMIN) || (state_reg == S_QD));
    assign sqrt_start = kick_reg && (state_reg == S_SQRT);

    pbt_mul #(.AW(MA), .BW(MB)) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .stat  (mul_stat),
        .prod  (mul_prod)
    );

    pbt_div #(.NW(NW), .DW(DW)) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (div_num),
        .den    (div_den),
        .stat   (div_stat),
        .quo    (div_quo),
        .rem_nz (div_rem_nz)
    );

    pbt_sqrt #(.RW(DW)) u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .rad   (r_reg),
        .stat  (sqrt_stat),
        .root  (sqrt_root)
    );

    assign in_acc   = sample_in.valid && sample_in.ready;
    assign cfg_acc  = cfg.valid && cfg.ready;
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || result_out.ready);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        kick_next  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = blend_valid_reg ? S_K1 : S_T2;
                    kick_next  = 1'b1;
                end
            end
            S_T2:
            begin
                if (mul_stat.done)
                begin
                    state_next = S_AMIN;
                    kick_next  = 1'b1;
                end
            end
            S_AMIN:
            begin
                if (div_stat.done)
                begin
                    // zero acceleration: blend time stays zero
                    state_next = (anew == '0) ? S_K1 : S_QD;
                    kick_next  = 1'b1;
                end
            end
            S_QD:
            begin
                if (div_stat.done)
                begin
                    state_next = S_SQRT;
                    kick_next  = 1'b1;
                end
            end
            S_SQRT:
            begin
                if (sqrt_stat.done)
                begin
                    state_next = S_K1;
                    kick_next  = 1'b1;
                end
            end
            S_K1:
            begin
                if (mul_stat.done)
                begin
                    state_next = (phase == PH_DECEL) ? S_K2 : S_SCALE;
                    kick_next  = 1'b1;
                end
            end
            S_K2:
            begin
                if (mul_stat.done)
                begin
                    state_next = S_SCALE;
                    kick_next  = 1'b1;
                end
            end
            S_SCALE:
            begin
                if (mul_stat.done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            kick_reg        <= 1'b0;
            start_reg       <= '0;
            end_reg         <= '0;
            ttime_reg       <= W'(1) << F;
            areq_reg        <= W'(1) << F;
            blend_time_reg  <= '0;
            blend_accel_reg <= '0;
            blend_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            kick_reg  <= kick_next;

            if (cfg_acc)
            begin
                case (cfg.index)
                    REG_START_POS:  start_reg <= cfg.data;
                    REG_END_POS:    end_reg   <= cfg.data;
                    REG_TOTAL_TIME: ttime_reg <= cfg.data;
                    REG_ACCEL_REQ:  areq_reg  <= cfg.data;
                    default:        ;
                endcase
                // drop the cached blend on any known register
                if ((cfg.index == REG_START_POS) || (cfg.index == REG_END_POS)
                    || (cfg.index == REG_TOTAL_TIME) || (cfg.index == REG_ACCEL_REQ))
                begin
                    blend_valid_reg <= 1'b0;
                end
            end

            if ((state_reg == S_AMIN) && div_stat.done && (anew == '0))
            begin
                blend_time_reg  <= '0;
                blend_accel_reg <= '0;
                blend_valid_reg <= 1'b1;
            end
            if ((state_reg == S_SQRT) && sqrt_stat.done)
            begin
                blend_time_reg  <= tb_new;
                blend_accel_reg <= down ? (-W'(acalc_reg)) : W'(acalc_reg);
                blend_valid_reg <= 1'b1;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath holding registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            t_reg <= sample_in.sample_time;
        end
        if ((state_reg == S_T2) && mul_stat.done)
        begin
            t2_reg <= mul_prod[DW-1:0];
        end
        if ((state_reg == S_AMIN) && div_stat.done)
        begin
            acalc_reg <= anew;
        end
        if ((state_reg == S_QD) && div_stat.done)
        begin
            r_reg <= (quarter_x > qd_x) ? DW'(quarter_x - qd_x) : '0;
        end
        if ((state_reg == S_K1) && mul_stat.done)
        begin
            k_reg <= mul_prod[MA-1:0];
        end
        if ((state_reg == S_K2) && mul_stat.done)
        begin
            k_reg <= k_reg - mul_prod[MA-1:0];
        end
        if (out_load)
        begin
            out_pos_reg   <= pos_fin;
            out_phase_reg <= phase;
            out_sat_reg   <= sat_fin;
        end
    end

    assign sample_in.ready      = (state_reg == S_IDLE);
    assign cfg.ready            = 1'b1;
    assign result_out.valid     = out_valid_reg;
    assign result_out.position  = out_pos_reg;
    assign result_out.phase     = out_phase_reg;
    assign result_out.saturated = out_sat_reg;

    // A result word only appears out of the final state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result word without finished computation");

    // Profile evaluation always runs on a solved blend
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_K1) |-> blend_valid_reg)
        else $error("profile evaluated without a blend");

    // Blend time never exceeds half the duration
    assert property (@(posedge clk) disable iff (!rst_n)
        blend_valid_reg |-> (blend_time_reg <= half))
        else $error("blend time beyond half duration");

    // Writing the total-time register while idle drops the cached blend
    assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_acc && (cfg.index == REG_TOTAL_TIME) && (state_reg == S_IDLE))
        |=> !blend_valid_reg)
        else $error("blend kept after register write");

    // Never restart a serial unit while it is still running
    assert property (@(posedge clk) disable iff (!rst_n)
        !(mul_start && mul_stat.busy) && !(div_start && div_stat.busy)
        && !(sqrt_start && sqrt_stat.busy))
        else $error("serial unit restarted while busy");
endmodule
`default_nettype wire

### tb/tb_top.sv
`default_nettype none
module tb_top;
    import pbt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int W = 32;
    // An index past the end of the register list; the block must drop the word.
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd6;
    localparam logic [63:0] ACCEL_MAX = 64'h7FFF_FFFF;

    typedef struct {
        logic [W-1:0] position;
        logic [1:0]   phase;
        logic         saturated;
    } pos_expect_t;

    logic clk;
    logic rst_n;

    pbt_sample_if #(.WORD_WIDTH(W)) s_if ();
    pbt_result_if #(.WORD_WIDTH(W)) r_if ();
    pbt_cfg_if #(.WORD_WIDTH(W), .INDEX_W(CFG_INDEX_W)) c_if ();

    parabolic_blend_trajectory_top #(.WORD_WIDTH(W), .FRAC_BITS(16)) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_in  (s_if.sink),
        .result_out (r_if.source),
        .cfg        (c_if.sink)
    );

    // Clock: 12 ns period.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the registers and the blend cache.
    // ------------------------------------------------------------------
    logic signed [W-1:0] cur_start;
    logic signed [W-1:0] cur_end;
    logic [W-1:0]        cur_total;
    logic signed [W-1:0] cur_accel;
    logic [W-1:0]        blend_tb;
    logic signed [W-1:0] blend_acc;
    bit                  blend_ok;

    pos_expect_t  expected_q[$];
    logic [W-1:0] sample_q[$];
    bit           sample_held;
    int           errors;
    int           src_idle_pct;
    int           snk_idle_pct;
    int           hold_left;

    function automatic logic [63:0] floor_sqrt(logic [127:0] x);
        logic [127:0] trial;
        logic [127:0] root;
        root = '0;
        for (int b = 63; b >= 0; b--)
        begin
            trial = root | (128'd1 << b);
            if (trial * trial <= x)
                root = trial;
        end
        return root[63:0];
    endfunction

    // Solve for the blend time and the clamped, direction-signed acceleration.
    function automatic void solve_blend();
        logic signed [63:0] p0, pf, ar;
        logic [63:0]        span, dur, acc, amin, root, half, tb;
        logic [127:0]       t2, num, q, qd, quarter, rad;
        bit                 down;
        p0   = cur_start;
        pf   = cur_end;
        ar   = cur_accel;
        down = p0 > pf;
        span = down ? p0 - pf : pf - p0;
        dur  = (cur_total == 0) ? 64'd1 : 64'(cur_total);
        acc  = ar < 0 ? -ar : ar;
        t2   = 128'(dur) * 128'(dur);
        // Lower bound 4*d/T^2, rounded up.
        num  = 128'(span) << 34;
        q    = num / t2;
        if (num % t2 != 0)
            q = q + 1;
        amin = (q > 128'(ACCEL_MAX)) ? ACCEL_MAX : q[63:0];
        if (acc < amin)
            acc = amin;
        if (acc > ACCEL_MAX)
            acc = ACCEL_MAX;
        tb = 0;
        if (acc != 0)
        begin
            qd      = (128'(span) << 32) / 128'(acc);
            quarter = t2 >> 2;
            rad     = quarter > qd ? quarter - qd : 128'd0;
            root    = floor_sqrt(rad);
            half    = dur >> 1;
            tb      = half > root ? half - root : 64'd0;
        end
        blend_tb  = tb[W-1:0];
        blend_acc = down ? -acc[W-1:0] : acc[W-1:0];
        blend_ok  = 1'b1;
    endfunction

    function automatic pos_expect_t plan_position(logic [W-1:0] t_in);
        pos_expect_t        e;
        logic [63:0]        t, dur, tb, acc, u;
        logic [127:0]       k, prod_lo, m;
        logic [191:0]       prod;
        logic signed [63:0] p0, sa, pos;
        bit                 neg, sat;
        if (!blend_ok)
            solve_blend();
        t   = t_in;
        dur = (cur_total == 0) ? 64'd1 : 64'(cur_total);
        tb  = blend_tb;
        sa  = blend_acc;
        neg = sa < 0;
        acc = neg ? -sa : sa;
        p0  = cur_start;
        sat = 1'b0;
        if (t <= tb)
        begin
            e.phase = PH_ACCEL;
            k = 128'(t) * 128'(t);
        end
        else if (t <= dur - tb)
        begin
            e.phase = PH_CRUISE;
            k = 128'(tb) * 128'(64'd2 * t - tb);
        end
        else
        begin
            u = t > dur ? 64'd0 : dur - t;
            e.phase = PH_DECEL;
            k = 128'(64'd2 * tb) * 128'(dur - tb) - 128'(u) * 128'(u);
        end
        // Product saturates at the top of 128 bits before the shift.
        prod    = 192'(k) * 192'(acc);
        prod_lo = (prod[191:128] != 0) ? {128{1'b1}} : prod[127:0];
        m       = prod_lo >> 33;
        if (m > 128'h1_FFFF_FFFE)
        begin
            sat = 1'b1;
            pos = neg ? -64'sh8000_0000 : 64'sh7FFF_FFFF;
        end
        else
        begin
            pos = neg ? p0 - $signed(m[63:0]) : p0 + $signed(m[63:0]);
            if (pos > 64'sh7FFF_FFFF)
            begin
                pos = 64'sh7FFF_FFFF;
                sat = 1'b1;
            end
            if (pos < -64'sh8000_0000)
            begin
                pos = -64'sh8000_0000;
                sat = 1'b1;
            end
        end
        e.position  = pos[W-1:0];
        e.saturated = sat;
        return e;
    endfunction

    task automatic report_mismatch(string field, logic [W-1:0] got, logic [W-1:0] want);
        $display("%0t mismatch on %s: got %h, expected %h", $realtime, field, got, want);
        errors++;
    endtask

    // ------------------------------------------------------------------
    // Sample driver: present words at the falling edge, hold valid until taken.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && !sample_held)
        begin
            if (sample_q.size() > 0 && $urandom_range(99) >= src_idle_pct)
            begin
                s_if.sample_time <= sample_q.pop_front();
                s_if.valid       <= 1'b1;
                sample_held = 1'b1;
            end
            else
                s_if.valid <= 1'b0;
        end
    end

    // Receiver: a long hold-off wins over the random stall pattern.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            r_if.ready <= 1'b0;
            hold_left--;
        end
        else
            r_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // Sample at the rising edge: predict on acceptance, check each result word.
    always @(posedge clk)
    begin
        pos_expect_t e;
        if (rst_n && s_if.valid && s_if.ready)
        begin
            expected_q.push_back(plan_position(s_if.sample_time));
            sample_held = 1'b0;
        end
        if (rst_n && r_if.valid && r_if.ready)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t result word with nothing expected", $realtime);
                errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (r_if.position !== e.position)
                    report_mismatch("position", r_if.position, e.position);
                if (r_if.phase !== e.phase)
                    report_mismatch("phase", 32'(r_if.phase), 32'(e.phase));
                if (r_if.saturated !== e.saturated)
                    report_mismatch("saturated", 32'(r_if.saturated), 32'(e.saturated));
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared tasks
    // ------------------------------------------------------------------
    task automatic send_sample(logic [W-1:0] t);
        sample_q.push_back(t);
        while (sample_q.size() > 0 || sample_held)
            @(posedge clk);
    endtask

    // Hold until every sample is taken and every result has come back.
    task automatic drain();
        while (sample_q.size() > 0 || sample_held || expected_q.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Write one register while the block is idle, and mirror it.
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [W-1:0] value);
        drain();
        @(negedge clk);
        c_if.index <= idx;
        c_if.data  <= value;
        c_if.valid <= 1'b1;
        @(posedge clk);
        while (!c_if.ready)
            @(posedge clk);
        case (idx)
            REG_START_POS:  cur_start = value;
            REG_END_POS:    cur_end   = value;
            REG_TOTAL_TIME: cur_total = value;
            REG_ACCEL_REQ:  cur_accel = value;
            default:        ;
        endcase
        if (idx <= REG_ACCEL_REQ)
            blend_ok = 1'b0;
        @(negedge clk);
        c_if.valid <= 1'b0;
    endtask

    task automatic load_profile(logic [W-1:0] p0, logic [W-1:0] pf,
                                logic [W-1:0] dur, logic [W-1:0] acc);
        write_reg(REG_START_POS, p0);
        write_reg(REG_END_POS, pf);
        write_reg(REG_TOTAL_TIME, dur);
        write_reg(REG_ACCEL_REQ, acc);
    endtask

    // Random magnitude spread over many octaves, random sign.
    function automatic logic [W-1:0] spread_signed();
        logic [W-1:0] v;
        v = $urandom >> $urandom_range(0, 31);
        return $urandom_range(1) ? -v : v;
    endfunction

    function automatic logic [W-1:0] pick_time();
        logic [63:0] dur;
        dur = (cur_total == 0) ? 64'd1 : 64'(cur_total);
        case ($urandom_range(9))
            0:       return $urandom;
            1:       return blend_tb;
            2:       return cur_total - blend_tb;
            3:       return cur_total;
            default: return 32'((64'($urandom) * (dur + (dur >> 2))) >> 32);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_reset_defaults();
        // Zero distance: position stays at start, blend time is zero.
        send_sample(32'h0000_0000);
        send_sample(32'h0000_8000);
        send_sample(32'h0001_0000);
        send_sample(32'hFFFF_FFFF);
    endtask

    task automatic test_directed();
        // Acceleration raised to the minimum; the blend fills the move, so only accel and decel occur.
        load_profile(32'h0000_0000, 32'h000A_0000, 32'h0002_0000, 32'h0001_0000);
        send_sample(32'h0000_0000);
        send_sample(32'h0000_4000);
        send_sample(32'h0001_0000);
        send_sample(32'h0001_C000);
        send_sample(32'h0002_0000);
        send_sample(32'h0003_0000);
        // Downward motion with a large request, so the cruise segment is long.
        load_profile(32'h0005_0000, 32'hFFFB_0000, 32'h0004_0000, 32'h8000_0000);
        send_sample(32'h0000_2000);
        send_sample(32'h0002_0000);
        send_sample(32'h0003_F000);
        // Full-range travel over one LSB of time: clip and saturate.
        load_profile(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF);
        send_sample(32'h0000_0000);
        send_sample(32'h0000_0001);
        send_sample(32'hFFFF_FFFF);
        // Zero duration is taken as one LSB; zero request uses the floor.
        load_profile(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
        send_sample(32'h0000_0001);
        send_sample(32'h0000_0000);
        // Longest duration; an ignored index must keep the cached blend.
        load_profile(32'h0000_0000, 32'h0100_0000, 32'hFFFF_FFFF, 32'h0000_0100);
        send_sample(32'h8000_0000);
        write_reg(REG_UNUSED, 32'hDEAD_BEEF);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'hFFFF_FFFF);
    endtask

    task automatic test_random_traffic(int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
            begin
                load_profile(spread_signed(), spread_signed(),
                             ($urandom_range(19) == 0) ? 32'd0 : ($urandom >> $urandom_range(0, 28)),
                             spread_signed());
                if ($urandom_range(3) == 0)
                    write_reg(3'($urandom_range(4, 7)), $urandom);
            end
            send_sample(pick_time());
        end
    endtask

    task automatic test_output_backpressure();
        load_profile(32'h0000_0000, 32'h0010_0000, 32'h0000_8000, 32'h0000_4000);
        drain();
        // Stall the receiver long enough for the block to stop taking samples.
        hold_left = 2000;
        for (int i = 0; i < 30; i++)
            send_sample(pick_time());
        // Pause the sender until every result is back, then burst again.
        drain();
        for (int i = 0; i < 10; i++)
            send_sample(pick_time());
    endtask

    // Limit on the whole run.
    initial
    begin
        #80_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        rst_n            = 1'b0;
        s_if.valid       = 1'b0;
        s_if.sample_time = '0;
        r_if.ready       = 1'b0;
        c_if.valid       = 1'b0;
        c_if.index       = '0;
        c_if.data        = '0;
        errors       = 0;
        hold_left    = 0;
        sample_held  = 1'b0;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        cur_start    = '0;
        cur_end      = '0;
        cur_total    = 32'h0001_0000;
        cur_accel    = 32'h0001_0000;
        blend_tb     = '0;
        blend_acc    = '0;
        blend_ok     = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_directed();

        // Receiver idles often, then the sender, then neither.
        src_idle_pct = 35;
        snk_idle_pct = 81;
        test_random_traffic(440);
        src_idle_pct = 81;
        snk_idle_pct = 35;
        test_random_traffic(440);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_random_traffic(440);
        test_output_backpressure();

        drain();
        repeat (400) @(posedge clk);
        if (errors == 0 && expected_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
`default_nettype wire

### sim.f
src/pbt_pkg.sv
src/pbt_if.sv
src/pbt_mul.sv
src/pbt_div.sv
src/pbt_sqrt.sv
src/parabolic_blend_trajectory_top.sv
tb/tb_top.sv
